// ----- src/mpr_pkg.sv -----
// Shared types and codes for the MQTT packet receiver.
// Used by every module of the block except mpr_ram; depends on nothing.
package mpr_pkg;

	localparam int SIZE_W = 13;

	localparam logic [1:0] PH_HEADER = 2'd0;
	localparam logic [1:0] PH_LENGTH = 2'd1;
	localparam logic [1:0] PH_DATA   = 2'd2;

	localparam logic [1:0] K_EVENT  = 2'd0;
	localparam logic [1:0] K_READ   = 2'd1;
	localparam logic [1:0] K_DECODE = 2'd2;

	localparam logic [3:0] EV_CONNACK   = 4'd0;
	localparam logic [3:0] EV_PINGRESP  = 4'd1;
	localparam logic [3:0] EV_SUBACK    = 4'd2;
	localparam logic [3:0] EV_PUBLISH   = 4'd3;
	localparam logic [3:0] EV_UNHANDLED = 4'd4;
	localparam logic [3:0] EV_MALFORMED = 4'd5;
	localparam logic [3:0] EV_BADHEADER = 4'd6;
	localparam logic [3:0] EV_OVERFLOW  = 4'd7;
	localparam logic [3:0] EV_READ      = 4'd8;

	localparam logic [3:0] T_CONNECT  = 4'd1;
	localparam logic [3:0] T_CONNACK  = 4'd2;
	localparam logic [3:0] T_PUBLISH  = 4'd3;
	localparam logic [3:0] T_SUBACK   = 4'd9;
	localparam logic [3:0] T_PINGREQ  = 4'd12;
	localparam logic [3:0] T_PINGRESP = 4'd13;

	typedef struct packed {
		logic [1:0]        kind;
		logic [3:0]        ev;
		logic [7:0]        hdr;
		logic [SIZE_W-1:0] size;
		logic [1:0]        lbc;
		logic [7:0]        addr;
	} cmd_t;

	typedef struct packed {
		logic [3:0]  event_res;
		logic        session_present;
		logic [7:0]  return_code;
		logic [15:0] packet_id;
		logic        dup_flag;
		logic [1:0]  qos_level;
		logic        retain_flag;
		logic [7:0]  topic_offset;
		logic [7:0]  topic_length;
		logic [8:0]  payload_offset;
		logic [8:0]  payload_length;
		logic [7:0]  read_data;
	} res_t;

endpackage

// ----- src/mqtt_packet_receiver_core.sv -----
// MQTT control packet receiver, top level.
// Depends on mpr_pkg, mpr_front, mpr_queue, mpr_back and mpr_ram.
//
// Input channel (in_valid/in_ready): one request per accepted item, either a
// received link byte (action 0) or a read of the packet store (action 1).
// Output channel (out_valid/out_ready): one event per completed packet, per
// header or overflow error, and per store read; other bytes give no event.
// Received bytes that frame a packet are taken one per cycle while the queue
// has room and no read or decode is pending. An event with no store access
// goes from the queue to the result register; a store read or a decode fetches
// each store byte in turn (up to 4 for a decode). Bytes wait until a pending
// read or decode passes its result out, so no store write meets a read.
// A two-entry command queue and the result register decouple the two sides:
// a stalled receiver fills the queue, then in_ready drops.
// Reset clears the framing phase and counters, the queue and the output valid
// flag; the result register and store contents are undefined until written.
module mqtt_packet_receiver_core #(
	parameter int BUF_BYTES = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        action,
	input  logic [7:0]  rx_byte,
	input  logic [7:0]  read_address,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [3:0]  event_res,
	output logic        session_present,
	output logic [7:0]  return_code,
	output logic [15:0] packet_id,
	output logic        dup_flag,
	output logic [1:0]  qos_level,
	output logic        retain_flag,
	output logic [7:0]  topic_offset,
	output logic [7:0]  topic_length,
	output logic [8:0]  payload_offset,
	output logic [8:0]  payload_length,
	output logic [7:0]  read_data
);
	import mpr_pkg::*;

	localparam int AW = $clog2(BUF_BYTES);

	logic          acc, push, pop, q_empty, q_full, we, re, done, busy;
	cmd_t          cmd, head;
	res_t          res;
	logic [AW-1:0] waddr, raddr;
	logic [7:0]    wdata, rdata;
	logic [1:0]    rd_pend_q;

	assign in_ready = !q_full && (action || rd_pend_q == 2'd0);
	assign acc      = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_pend_q <= 2'd0;
		end else begin
			rd_pend_q <= rd_pend_q + {1'b0, push && cmd.kind != K_EVENT} - {1'b0, done};
		end
	end

	mpr_front #(.BUF_BYTES(BUF_BYTES)) u_front (
		.clk, .arst_n, .acc, .action, .rx_byte, .read_address,
		.push, .cmd, .we, .waddr, .wdata
	);

	mpr_queue u_queue (
		.clk, .arst_n, .push, .din(cmd), .pop, .head, .empty(q_empty), .full(q_full)
	);

	mpr_back #(.BUF_BYTES(BUF_BYTES)) u_back (
		.clk, .arst_n, .q_valid(!q_empty), .q_head(head), .pop, .re, .raddr, .rdata,
		.out_valid, .out_ready, .out_res(res), .done, .busy
	);

	mpr_ram #(.WIDTH(8), .DEPTH(BUF_BYTES)) u_store (
		.clk, .we, .waddr, .wdata, .re, .raddr, .rdata
	);

	assign event_res       = res.event_res;
	assign session_present = res.session_present;
	assign return_code     = res.return_code;
	assign packet_id       = res.packet_id;
	assign dup_flag        = res.dup_flag;
	assign qos_level       = res.qos_level;
	assign retain_flag     = res.retain_flag;
	assign topic_offset    = res.topic_offset;
	assign topic_length    = res.topic_length;
	assign payload_offset  = res.payload_offset;
	assign payload_length  = res.payload_length;
	assign read_data       = res.read_data;

	a_no_write_during_read: assert property (@(posedge clk) disable iff (!arst_n)
		we |-> rd_pend_q == 2'd0) else $error("store written while a read is pending");

	a_done_has_pending: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> rd_pend_q != 2'd0) else $error("read completion without pending read");

	a_idle_no_pending: assert property (@(posedge clk) disable iff (!arst_n)
		(q_empty && !busy) |-> rd_pend_q == 2'd0) else $error("pending count leaked");

endmodule

// ----- src/mpr_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mpr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

// ----- src/mpr_front.sv -----
// Front end: frames received bytes, writes the packet store, issues commands.
// Depends on mpr_pkg.
module mpr_front #(
	parameter int BUF_BYTES = 256,
	localparam int AW = $clog2(BUF_BYTES)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          acc,
	input  logic          action,
	input  logic [7:0]    rx_byte,
	input  logic [7:0]    read_address,
	output logic          push,
	output mpr_pkg::cmd_t cmd,
	output logic          we,
	output logic [AW-1:0] waddr,
	output logic [7:0]    wdata
);
	import mpr_pkg::*;

	localparam int FW = $clog2(BUF_BYTES + 1);

	logic [1:0]    phase_q, phase_n;
	logic [FW-1:0] fill_q, fill_n;
	logic [20:0]   acc_q, acc_n, acc_sum;
	logic [1:0]    lbc_q, lbc_n;
	logic [20:0]   rem_q, rem_n, rem_dec;
	logic [7:0]    hdr_q, hdr_n;
	logic          full, hdr_ok;

	assign full    = fill_q >= FW'(BUF_BYTES);
	assign acc_sum = acc_q + (21'(rx_byte[6:0]) << (5'(lbc_q) * 5'd7));
	assign rem_dec = (rem_q != 21'd0) ? rem_q - 21'd1 : 21'd0;

	always_comb begin
		case (rx_byte[7:4])
			T_PUBLISH: hdr_ok = 1'b1;
			T_CONNECT, T_CONNACK, T_SUBACK, T_PINGREQ, T_PINGRESP:
				hdr_ok = (rx_byte[3:0] == 4'd0);
			default: hdr_ok = 1'b0;
		endcase
	end

	always_comb begin
		phase_n = phase_q;
		fill_n  = fill_q;
		acc_n   = acc_q;
		lbc_n   = lbc_q;
		rem_n   = rem_q;
		hdr_n   = hdr_q;
		push    = 1'b0;
		cmd     = '0;
		cmd.hdr = hdr_q;
		we      = 1'b0;
		waddr   = fill_q[AW-1:0];
		wdata   = rx_byte;
		if (acc) begin
			if (action) begin
				push     = 1'b1;
				cmd.kind = K_READ;
				cmd.addr = read_address;
			end else begin
				case (phase_q)
					PH_LENGTH: begin
						if (full) begin
							push = 1'b1; cmd.kind = K_EVENT; cmd.ev = EV_OVERFLOW;
							phase_n = PH_HEADER; fill_n = '0; acc_n = '0; lbc_n = '0; rem_n = '0;
						end else begin
							we     = 1'b1;
							fill_n = fill_q + 1'b1;
							if (lbc_q == 2'd3) begin
								push = 1'b1; cmd.kind = K_EVENT; cmd.ev = EV_BADHEADER;
								phase_n = PH_HEADER; fill_n = '0; acc_n = '0; lbc_n = '0;
								rem_n = '0;
							end else begin
								acc_n = acc_sum;
								lbc_n = lbc_q + 2'd1;
								if (!rx_byte[7]) begin
									rem_n   = acc_sum;
									phase_n = PH_DATA;
									if (acc_sum == 21'd0) begin
										push     = 1'b1;
										cmd.kind = K_DECODE;
										cmd.size = SIZE_W'(fill_n);
										cmd.lbc  = lbc_q + 2'd1;
										phase_n = PH_HEADER; fill_n = '0; acc_n = '0;
										lbc_n = '0; rem_n = '0;
									end
								end
							end
						end
					end
					PH_DATA: begin
						if (full) begin
							push = 1'b1; cmd.kind = K_EVENT; cmd.ev = EV_OVERFLOW;
							phase_n = PH_HEADER; fill_n = '0; acc_n = '0; lbc_n = '0; rem_n = '0;
						end else begin
							we     = 1'b1;
							fill_n = fill_q + 1'b1;
							rem_n  = rem_dec;
							if (rem_dec == 21'd0) begin
								push     = 1'b1;
								cmd.kind = K_DECODE;
								cmd.size = SIZE_W'(fill_n);
								cmd.lbc  = lbc_q;
								phase_n = PH_HEADER; fill_n = '0; acc_n = '0; lbc_n = '0;
								rem_n = '0;
							end
						end
					end
					default: begin
						phase_n = PH_HEADER; fill_n = '0; acc_n = '0; lbc_n = '0; rem_n = '0;
						if (!hdr_ok) begin
							push = 1'b1; cmd.kind = K_EVENT; cmd.ev = EV_BADHEADER;
						end else begin
							we      = 1'b1;
							waddr   = '0;
							fill_n  = FW'(1);
							hdr_n   = rx_byte;
							phase_n = PH_LENGTH;
						end
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HEADER;
			fill_q  <= '0;
			acc_q   <= '0;
			lbc_q   <= '0;
			rem_q   <= '0;
		end else begin
			phase_q <= phase_n;
			fill_q  <= fill_n;
			acc_q   <= acc_n;
			lbc_q   <= lbc_n;
			rem_q   <= rem_n;
		end
	end

	always_ff @(posedge clk) begin
		hdr_q <= hdr_n;
	end
endmodule

// ----- src/mpr_queue.sv -----
// Two-entry command queue between front end and back end.
// Depends on mpr_pkg.
module mpr_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  mpr_pkg::cmd_t din,
	input  logic          pop,
	output mpr_pkg::cmd_t head,
	output logic          empty,
	output logic          full
);
	import mpr_pkg::*;

	cmd_t       ent_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;

	assign empty = (cnt_q == 2'd0);
	assign full  = (cnt_q == 2'd2);
	assign head  = ent_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop)  rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wp_q] <= din;
		end
	end
endmodule

// ----- src/mpr_back.sv -----
// Back end: forwards events, executes store reads and packet decodes, holds the result register.
// Depends on mpr_pkg; drives the read port of the packet store.
module mpr_back #(
	parameter int BUF_BYTES = 256,
	localparam int AW = $clog2(BUF_BYTES)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          q_valid,
	input  mpr_pkg::cmd_t q_head,
	output logic          pop,
	output logic          re,
	output logic [AW-1:0] raddr,
	input  logic [7:0]    rdata,
	output logic          out_valid,
	input  logic          out_ready,
	output mpr_pkg::res_t out_res,
	output logic          done,
	output logic          busy
);
	import mpr_pkg::*;

	localparam logic [1:0] B_IDLE  = 2'd0;
	localparam logic [1:0] B_FETCH = 2'd1;
	localparam logic [1:0] B_DATA  = 2'd2;
	localparam logic [1:0] B_EMIT  = 2'd3;

	logic [1:0]    st_q, st_n;
	cmd_t          cmd_q, cmd_n;
	res_t          res_q, res_n, out_q;
	logic [AW-1:0] raddr_q, raddr_n;
	logic [1:0]    cnt_q, cnt_n;
	logic [7:0]    col_q;
	logic [17:0]   pos_q, pos_n, pos0, pos2, size18;
	logic          out_valid_q, out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign out_res   = out_q;
	assign raddr     = raddr_q;
	assign busy      = (st_q != B_IDLE);
	assign pos0      = 18'(q_head.lbc) + 18'd1;
	assign size18    = 18'(cmd_q.size);
	assign pos2      = pos_q + 18'd2 + 18'({col_q, rdata});

	always_comb begin
		st_n    = st_q;
		cmd_n   = cmd_q;
		res_n   = res_q;
		raddr_n = raddr_q;
		cnt_n   = cnt_q;
		pos_n   = pos_q;
		pop     = 1'b0;
		re      = 1'b0;
		done    = 1'b0;
		case (st_q)
			B_IDLE: begin
				if (q_valid) begin
					pop   = 1'b1;
					cmd_n = q_head;
					res_n = '0;
					cnt_n = 2'd0;
					st_n  = B_EMIT;
					case (q_head.kind)
						K_EVENT: res_n.event_res = q_head.ev;
						K_READ: begin
							res_n.event_res = EV_READ;
							if (32'(q_head.addr) < BUF_BYTES) begin
								raddr_n = AW'(q_head.addr);
								st_n    = B_FETCH;
							end
						end
						default: begin
							case (q_head.hdr[7:4])
								T_CONNACK: begin
									if (q_head.size != SIZE_W'(4)) begin
										res_n.event_res = EV_MALFORMED;
									end else begin
										res_n.event_res = EV_CONNACK;
										raddr_n = AW'(2);
										st_n    = B_FETCH;
									end
								end
								T_PINGRESP: res_n.event_res =
									(q_head.size != SIZE_W'(2)) ? EV_MALFORMED : EV_PINGRESP;
								T_SUBACK: begin
									if (q_head.size != SIZE_W'(5)) begin
										res_n.event_res = EV_MALFORMED;
									end else begin
										res_n.event_res = EV_SUBACK;
										raddr_n = AW'(2);
										st_n    = B_FETCH;
									end
								end
								T_PUBLISH: begin
									if (pos0 + 18'd2 > 18'(q_head.size)) begin
										res_n.event_res = EV_MALFORMED;
									end else begin
										res_n.event_res   = EV_PUBLISH;
										res_n.dup_flag    = q_head.hdr[3];
										res_n.qos_level   = q_head.hdr[2:1];
										res_n.retain_flag = q_head.hdr[0];
										raddr_n = AW'(pos0);
										pos_n   = pos0;
										st_n    = B_FETCH;
									end
								end
								default: res_n.event_res = EV_UNHANDLED;
							endcase
						end
					endcase
				end
			end
			B_FETCH: begin
				re   = 1'b1;
				st_n = B_DATA;
			end
			B_DATA: begin
				cnt_n   = cnt_q + 2'd1;
				raddr_n = raddr_q + 1'b1;
				st_n    = B_FETCH;
				if (cmd_q.kind == K_READ) begin
					res_n.read_data = rdata;
					st_n = B_EMIT;
				end else begin
					case (cmd_q.hdr[7:4])
						T_CONNACK: begin
							if (cnt_q == 2'd0) begin
								res_n.session_present = rdata[0];
							end else begin
								res_n.return_code = rdata;
								st_n = B_EMIT;
							end
						end
						T_SUBACK: begin
							if (cnt_q == 2'd1) res_n.packet_id = {col_q, rdata};
							if (cnt_q == 2'd2) begin
								res_n.return_code = rdata;
								st_n = B_EMIT;
							end
						end
						default: begin
							if (cnt_q == 2'd1) begin
								res_n.topic_offset = pos_q[7:0] + 8'd2;
								res_n.topic_length = rdata;
								if (cmd_q.hdr[2:1] != 2'd0) begin
									if (pos2 + 18'd2 > size18) begin
										res_n = '0;
										res_n.event_res = EV_MALFORMED;
										st_n = B_EMIT;
									end else begin
										raddr_n = AW'(pos2);
										pos_n   = pos2 + 18'd2;
									end
								end else begin
									st_n = B_EMIT;
									if (pos2 > size18) begin
										res_n = '0;
										res_n.event_res = EV_MALFORMED;
									end else begin
										res_n.payload_offset = pos2[8:0];
										res_n.payload_length = 9'(size18 - pos2);
									end
								end
							end
							if (cnt_q == 2'd3) begin
								res_n.packet_id      = {col_q, rdata};
								res_n.payload_offset = pos_q[8:0];
								res_n.payload_length = 9'(size18 - pos_q);
								st_n = B_EMIT;
							end
						end
					endcase
				end
			end
			default: begin
				if (out_free) begin
					done = (cmd_q.kind != K_EVENT);
					st_n = B_IDLE;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= B_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			st_q <= st_n;
			if (st_q == B_EMIT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		cmd_q   <= cmd_n;
		res_q   <= res_n;
		raddr_q <= raddr_n;
		cnt_q   <= cnt_n;
		pos_q   <= pos_n;
		if (st_q == B_DATA) col_q <= rdata;
		if (st_q == B_EMIT && out_free) out_q <= res_q;
	end
endmodule
